// ===== src/dtf_pkg.sv =====
package dtf_pkg;

   // Character codes the parser recognizes.
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   localparam int IntWidth  = 31;
   localparam int FracWidth = 32;
   localparam logic [IntWidth-1:0] IntMax = 31'h7FFF_FFFF;

   // Everything the result stage needs to know about a finished string.
   typedef struct packed {
      logic                 bad;
      logic                 minus;
      logic [IntWidth-1:0]  integer_part;
      logic [FracWidth-1:0] fraction_part;
   } parse_result_type;

   // Weight of fraction digit k+1: floor(2^32 / 10^(k+1)).
   function automatic logic [FracWidth-1:0] frac_weight(input logic [3:0] k);
      logic [FracWidth-1:0] w;
      begin
         case (k)
            4'd0: w = 32'd429496729;
            4'd1: w = 32'd42949672;
            4'd2: w = 32'd4294967;
            4'd3: w = 32'd429496;
            4'd4: w = 32'd42949;
            4'd5: w = 32'd4294;
            4'd6: w = 32'd429;
            4'd7: w = 32'd42;
            4'd8: w = 32'd4;
            default: w = 32'd0;
         endcase
         frac_weight = w;
      end
   endfunction

endpackage

// ===== src/decimal_text_to_fixed.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    req_character [7:0]
// rsp_      out        rsp_valid/rsp_ready    rsp_value [63:0] signed, rsp_bad_format
// csr_      in         csr_valid/csr_ready    csr_base_sign [1:0] signed
//
// One character is taken per cycle. A transfer lands in the input register and
// is applied to the parser state from there; a terminator's step loads the
// result register, which drives the response. Reset is synchronous and active
// high; it clears the parser state and sets the sign register to +1. Only a
// terminator meeting a full, undrained result register stalls the input.
module decimal_text_to_fixed #(
   parameter int FRAC_DIGITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_character,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic               rsp_bad_format,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [1:0]  csr_base_sign
);

   logic                      char_valid_ff;
   logic [7:0]                char_ff;
   logic signed [1:0]         base_sign_ff;
   logic                      is_term;
   logic                      advance;
   logic                      result_free;
   dtf_pkg::parse_result_type parse_result;

   // The sign register is always writable; the user must write it only while idle, as the block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_sign_ff <= 2'sd1;
      end else if (csr_valid) begin
         base_sign_ff <= csr_base_sign;
      end
   end

   // The held character moves on unless it is a terminator whose result has
   // nowhere to go yet.
   assign is_term   = (char_ff == dtf_pkg::CharNul);
   assign advance   = char_valid_ff && (!is_term || result_free);
   assign req_ready = !char_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_valid_ff <= 1'b0;
      end else if (req_ready) begin
         char_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_character;
      end
   end

   dtf_parse #(
      .FRAC_DIGITS(FRAC_DIGITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .character (char_ff),
      .result    (parse_result)
   );

   // The terminator's step both builds the result and clears the parser.
   dtf_result u_result (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && is_term),
      .result         (parse_result),
      .base_sign      (base_sign_ff),
      .free           (result_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_bad_format (rsp_bad_format)
   );

`ifndef ASSERT_OFF
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_format |-> (rsp_value == 64'sd0))
      else $error("bad result carries a nonzero value");

   a_term_blocks: assert property (@(posedge clock) disable iff (reset)
      char_valid_ff && is_term && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while terminator is blocked");
`endif

endmodule

// ===== src/dtf_parse.sv =====
module dtf_parse #(
   parameter int FRAC_DIGITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                character,
   output dtf_pkg::parse_result_type result
);

   localparam int CountWidth = $clog2(FRAC_DIGITS + 1);

   typedef enum logic [2:0] {
      PhWs, PhSign, PhInt, PhDot, PhFrac, PhTrail, PhErr
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic                              minus_ff, minus_in;
   logic                              any_ff, any_in;
   logic [dtf_pkg::IntWidth-1:0]      int_ff, int_in;
   logic [dtf_pkg::FracWidth-1:0]     frac_ff, frac_in;
   logic [CountWidth-1:0]             count_ff, count_in;

   logic                              is_ws, is_digit;
   logic [3:0]                        digit;
   logic [dtf_pkg::IntWidth+3:0]      int_wide;
   logic [dtf_pkg::IntWidth-1:0]      int_next;
   logic [dtf_pkg::FracWidth-1:0]     frac_next;
   logic [CountWidth-1:0]             count_next;

   assign is_ws = ((character >= dtf_pkg::CharTab) && (character <= dtf_pkg::CharCr))
                  || (character == dtf_pkg::CharSpace);
   assign is_digit = (character >= dtf_pkg::CharZero) && (character <= dtf_pkg::CharNine);
   assign digit = character[3:0];

   // Integer digit: times ten plus the digit, clamped at the largest 31-bit integer part of the Q31.32 result.
   assign int_wide = (dtf_pkg::IntWidth+4)'(int_ff) * (dtf_pkg::IntWidth+4)'(10)
                     + (dtf_pkg::IntWidth+4)'(digit);
   assign int_next = (int_wide > (dtf_pkg::IntWidth+4)'(dtf_pkg::IntMax))
                     ? dtf_pkg::IntMax : int_wide[dtf_pkg::IntWidth-1:0];

   // Fraction digit: weighted add while digits remain, ignored afterwards.
   always_comb begin
      frac_next  = frac_ff;
      count_next = count_ff;
      if (count_ff < CountWidth'(FRAC_DIGITS)) begin
         frac_next  = frac_ff + dtf_pkg::FracWidth'(
                      36'(digit) * 36'(dtf_pkg::frac_weight(4'(count_ff))));
         count_next = count_ff + CountWidth'(1);
      end
   end

   always_comb begin
      phase_in = phase_ff;
      minus_in = minus_ff;
      any_in   = any_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      count_in = count_ff;
      if (step) begin
         if (character == dtf_pkg::CharNul) begin
            phase_in = PhWs;
            minus_in = 1'b0;
            any_in   = 1'b0;
            int_in   = '0;
            frac_in  = '0;
            count_in = '0;
         end else begin
            any_in = 1'b1;
            case (phase_ff)
               PhWs: begin
                  if (is_ws) begin
                     phase_in = PhWs;
                  end else if ((character == dtf_pkg::CharMinus)
                               || (character == dtf_pkg::CharPlus)) begin
                     minus_in = (character == dtf_pkg::CharMinus);
                     phase_in = PhSign;
                  end else if (is_digit) begin
                     int_in   = int_next;
                     phase_in = PhInt;
                  end else if (character == dtf_pkg::CharDot) begin
                     phase_in = PhDot;
                  end else begin
                     phase_in = PhErr;
                  end
               end
               PhSign, PhInt: begin
                  if (is_digit) begin
                     int_in   = int_next;
                     phase_in = PhInt;
                  end else if (character == dtf_pkg::CharDot) begin
                     phase_in = PhDot;
                  end else if (character == dtf_pkg::CharSpace) begin
                     phase_in = PhTrail;
                  end else begin
                     phase_in = PhErr;
                  end
               end
               PhDot: begin
                  if (is_digit) begin
                     frac_in  = frac_next;
                     count_in = count_next;
                     phase_in = PhFrac;
                  end else begin
                     phase_in = PhErr;
                  end
               end
               PhFrac: begin
                  if (is_digit) begin
                     frac_in  = frac_next;
                     count_in = count_next;
                  end else if (character == dtf_pkg::CharSpace) begin
                     phase_in = PhTrail;
                  end else begin
                     phase_in = PhErr;
                  end
               end
               PhTrail: begin
                  if (character != dtf_pkg::CharSpace) begin
                     phase_in = PhErr;
                  end
               end
               default: begin
                  phase_in = PhErr;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhWs;
         minus_ff <= 1'b0;
         any_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         any_ff   <= any_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         count_ff <= count_in;
      end
   end

   // A malformed string, a dangling dot or an empty string is reported as bad.
   assign result.bad = (phase_ff == PhErr) || (phase_ff == PhDot) || !any_ff;
   assign result.minus = minus_ff;
   assign result.integer_part = int_ff;
   assign result.fraction_part = frac_ff;

`ifndef ASSERT_OFF
   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      step && (character == dtf_pkg::CharNul)
      |=> (phase_ff == PhWs) && !any_ff && (count_ff == '0) && (int_ff == '0))
      else $error("parser state not cleared after terminator");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(FRAC_DIGITS))
      else $error("fraction digit count past its limit");
`endif

endmodule

// ===== src/dtf_result.sv =====
module dtf_result (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  dtf_pkg::parse_result_type result,
   input  logic signed [1:0]         base_sign,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [63:0]        rsp_value,
   output logic                      rsp_bad_format
);

   logic                valid_ff;
   logic [63:0]         value_ff, value_in;
   logic                bad_ff;
   logic [63:0]         magnitude;

   assign magnitude = {1'b0, result.integer_part, result.fraction_part};

   // A bad result is zero; else minus or a negative sign register negates, and a zero sign register zeroes the rest.
   always_comb begin
      if (result.bad) begin
         value_in = '0;
      end else if (result.minus || base_sign[1]) begin
         value_in = (~magnitude) + 64'd1;
      end else if (base_sign == 2'sd0) begin
         value_in = '0;
      end else begin
         value_in = magnitude;
      end
   end

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         bad_ff   <= result.bad;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_bad_format = bad_ff;

endmodule
